// File: sv/nearest_neighbor_crop_downscale_unit_macros.svh
// ----------------------------------------------------------------------------
// nearest neighbor crop downscale unit: assertion macros
// shorthand for clocked implication checks with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_CROP_DOWNSCALE_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_CROP_DOWNSCALE_UNIT_MACROS_SVH

// same-cycle implication
`define NNCD_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nncd check failed: same-cycle implication");

// next-cycle implication
`define NNCD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nncd check failed: next-cycle implication");

`endif

// File: sv/nncd_pkg.sv
// ----------------------------------------------------------------------------
// nncd_pkg
// shared constants and types of the crop and downscale unit
// ----------------------------------------------------------------------------
package nncd_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam int DEF_MAX_DIMENSION = 1024;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROP_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 3'd4;

    localparam int RST_SRC_WIDTH   = 320;
    localparam int RST_SRC_HEIGHT  = 240;
    localparam int RST_CROP_HEIGHT = 204;
    localparam int RST_OUT_WIDTH   = 96;
    localparam int RST_OUT_HEIGHT  = 96;

    localparam logic [PIX_W-1:0] PIXEL_OFFSET = 8'd128;

    // one output pixel
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_result;

    // remainder renormalization strobes after a size change
    typedef struct packed {
        logic col;
        logic row;
    } t_norm_ctl;

endpackage

// File: sv/nncd_div.sv
// ----------------------------------------------------------------------------
// nncd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nncd_div
    import nncd_pkg::*;
#(
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int CNT_W = $clog2(DW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        fits;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign trial   = shifted - {1'b0, r_div};
    assign fits    = !trial[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: sv/nncd_cfg.sv
// ----------------------------------------------------------------------------
// nncd_cfg
// size registers, clamping, step ratio recompute and remainder re-split after each write
// ----------------------------------------------------------------------------
module nncd_cfg
    import nncd_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int DW            = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [DW-1:0]        i_col_raw,
    input  logic [DW-1:0]        i_row_raw,
    output logic                 o_busy,
    output logic [DW-1:0]        o_sw,
    output logic [DW-1:0]        o_sh,
    output logic [DW-1:0]        o_ow,
    output logic [DW-1:0]        o_oh,
    output logic [DW-1:0]        o_qw,
    output logic [DW-1:0]        o_rw,
    output logic [DW-1:0]        o_qh,
    output logic [DW-1:0]        o_rh,
    output t_norm_ctl            o_norm,
    output logic [DW-1:0]        o_norm_quot,
    output logic [DW-1:0]        o_norm_rem
);

    // reset sizes after clamping
    localparam int RST_SW = (RST_SRC_WIDTH > MAX_DIMENSION) ? MAX_DIMENSION : RST_SRC_WIDTH;
    localparam int RST_SH = (RST_SRC_HEIGHT > MAX_DIMENSION) ? MAX_DIMENSION : RST_SRC_HEIGHT;
    localparam int RST_CH = (RST_CROP_HEIGHT > RST_SH) ? RST_SH : RST_CROP_HEIGHT;
    localparam int RST_OW = (RST_OUT_WIDTH > RST_SW) ? RST_SW : RST_OUT_WIDTH;
    localparam int RST_OH = (RST_OUT_HEIGHT > RST_CH) ? RST_CH : RST_OUT_HEIGHT;
    localparam int RST_QW = RST_SW / RST_OW;
    localparam int RST_RW = RST_SW % RST_OW;
    localparam int RST_QH = RST_CH / RST_OH;
    localparam int RST_RH = RST_CH % RST_OH;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_START  = 2'd2;
    localparam logic [1:0] ST_WAIT   = 2'd3;

    localparam logic [1:0] JOB_COL_RATIO = 2'd0;
    localparam logic [1:0] JOB_ROW_RATIO = 2'd1;
    localparam logic [1:0] JOB_COL_NORM  = 2'd2;
    localparam logic [1:0] JOB_ROW_NORM  = 2'd3;

    function automatic logic [15:0] clamp_dim(input logic [15:0] v, input logic [15:0] hi);
        logic [15:0] res;
        res = v;
        if (v == 16'd0) begin
            res = 16'd1;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    logic [CFG_W-1:0] r_src_width;
    logic [CFG_W-1:0] r_src_height;
    logic [CFG_W-1:0] r_crop_height;
    logic [CFG_W-1:0] r_out_width;
    logic [CFG_W-1:0] r_out_height;

    logic [DW-1:0] r_sw;
    logic [DW-1:0] r_sh;
    logic [DW-1:0] r_ch;
    logic [DW-1:0] r_ow;
    logic [DW-1:0] r_oh;
    logic [DW-1:0] r_qw;
    logic [DW-1:0] r_rw;
    logic [DW-1:0] r_qh;
    logic [DW-1:0] r_rh;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [1:0] r_job;
    logic [1:0] n_job;

    logic [15:0] c_sw;
    logic [15:0] c_sh;
    logic [15:0] c_ch;
    logic [15:0] c_ow;
    logic [15:0] c_oh;

    logic          cfg_write;
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic [DW-1:0] div_quot;
    logic [DW-1:0] div_rem;
    logic          job_done;

    assign c_sw = clamp_dim(16'(r_src_width), 16'(MAX_DIMENSION));
    assign c_sh = clamp_dim(16'(r_src_height), 16'(MAX_DIMENSION));
    assign c_ch = clamp_dim(16'(r_crop_height), c_sh);
    assign c_ow = clamp_dim(16'(r_out_width), c_sw);
    assign c_oh = clamp_dim(16'(r_out_height), c_ch);

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign div_start   = (r_state == ST_START);
    assign job_done    = (r_state == ST_WAIT) && div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= CFG_W'(RST_SRC_WIDTH);
            r_src_height  <= CFG_W'(RST_SRC_HEIGHT);
            r_crop_height <= CFG_W'(RST_CROP_HEIGHT);
            r_out_width   <= CFG_W'(RST_OUT_WIDTH);
            r_out_height  <= CFG_W'(RST_OUT_HEIGHT);
        end else if (cfg_write) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data;
                CFG_SRC_HEIGHT:  r_src_height  <= i_cfg_data;
                CFG_CROP_HEIGHT: r_crop_height <= i_cfg_data;
                CFG_OUT_WIDTH:   r_out_width   <= i_cfg_data;
                CFG_OUT_HEIGHT:  r_out_height  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= DW'(RST_SW);
            r_sh <= DW'(RST_SH);
            r_ch <= DW'(RST_CH);
            r_ow <= DW'(RST_OW);
            r_oh <= DW'(RST_OH);
        end else begin
            r_sw <= DW'(c_sw);
            r_sh <= DW'(c_sh);
            r_ch <= DW'(c_ch);
            r_ow <= DW'(c_ow);
            r_oh <= DW'(c_oh);
        end
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        case (r_state)
            ST_IDLE: begin
                if (cfg_write) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = ST_START;
                n_job   = JOB_COL_RATIO;
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    n_job   = r_job + 1'b1;
                    n_state = (r_job == JOB_ROW_NORM) ? ST_IDLE : ST_START;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_job   <= JOB_COL_RATIO;
            r_qw    <= DW'(RST_QW);
            r_rw    <= DW'(RST_RW);
            r_qh    <= DW'(RST_QH);
            r_rh    <= DW'(RST_RH);
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            if (job_done && r_job == JOB_COL_RATIO) begin
                r_qw <= div_quot;
                r_rw <= div_rem;
            end
            if (job_done && r_job == JOB_ROW_RATIO) begin
                r_qh <= div_quot;
                r_rh <= div_rem;
            end
        end
    end

    always_comb begin
        case (r_job)
            JOB_COL_RATIO: begin
                div_dividend = r_sw;
                div_divisor  = r_ow;
            end
            JOB_ROW_RATIO: begin
                div_dividend = r_ch;
                div_divisor  = r_oh;
            end
            JOB_COL_NORM: begin
                div_dividend = i_col_raw;
                div_divisor  = r_ow;
            end
            default: begin
                div_dividend = i_row_raw;
                div_divisor  = r_oh;
            end
        endcase
    end

    nncd_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_sw        = r_sw;
    assign o_sh        = r_sh;
    assign o_ow        = r_ow;
    assign o_oh        = r_oh;
    assign o_qw        = r_qw;
    assign o_rw        = r_rw;
    assign o_qh        = r_qh;
    assign o_rh        = r_rh;
    assign o_norm.col  = job_done && (r_job == JOB_COL_NORM);
    assign o_norm.row  = job_done && (r_job == JOB_ROW_NORM);
    assign o_norm_quot = div_quot;
    assign o_norm_rem  = div_rem;

endmodule

// File: sv/nncd_scan.sv
// ----------------------------------------------------------------------------
// nncd_scan
// raster scan counters and incremental nearest-neighbor pick
// ----------------------------------------------------------------------------
module nncd_scan
    import nncd_pkg::*;
#(
    parameter int DW = 11,
    parameter int TW = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    input  logic [DW-1:0]    i_sw,
    input  logic [DW-1:0]    i_sh,
    input  logic [DW-1:0]    i_ow,
    input  logic [DW-1:0]    i_oh,
    input  logic [DW-1:0]    i_qw,
    input  logic [DW-1:0]    i_rw,
    input  logic [DW-1:0]    i_qh,
    input  logic [DW-1:0]    i_rh,
    input  t_norm_ctl        i_norm,
    input  logic [DW-1:0]    i_norm_quot,
    input  logic [DW-1:0]    i_norm_rem,
    output logic [DW-1:0]    o_col_raw,
    output logic [DW-1:0]    o_row_raw,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [DW-1:0] r_scol, n_scol, r_srow, n_srow;
    logic [DW-1:0] r_ocol, n_ocol, r_orow, n_orow;
    logic [TW-1:0] r_ctgt, n_ctgt, r_rtgt, n_rtgt;
    logic [DW-1:0] r_craw, n_craw, r_rraw, n_rraw;
    logic [DW-1:0] r_cmod, n_cmod, r_rmod, n_rmod;
    logic [DW-1:0] r_cbonus, n_cbonus, r_rbonus, n_rbonus;

    // state as seen by this request, after an optional frame restart
    logic [DW-1:0] cur_scol, cur_srow, cur_ocol, cur_orow;
    logic [TW-1:0] cur_ctgt, cur_rtgt;
    logic [DW-1:0] cur_cmod, cur_rmod, cur_cbonus, cur_rbonus;

    logic          row_hit;
    logic          col_hit;
    logic          row_end;
    logic          frame_end;
    logic [DW:0]   csum, rsum;
    logic          ccarry, rcarry;
    logic [DW-1:0] cmod_step, rmod_step;
    logic [TW-1:0] ctgt_step, rtgt_step;

    assign cur_scol   = i_frame_start ? '0 : r_scol;
    assign cur_srow   = i_frame_start ? '0 : r_srow;
    assign cur_ocol   = i_frame_start ? '0 : r_ocol;
    assign cur_orow   = i_frame_start ? '0 : r_orow;
    assign cur_ctgt   = i_frame_start ? '0 : r_ctgt;
    assign cur_rtgt   = i_frame_start ? '0 : r_rtgt;
    assign cur_cmod   = i_frame_start ? '0 : r_cmod;
    assign cur_rmod   = i_frame_start ? '0 : r_rmod;
    assign cur_cbonus = i_frame_start ? '0 : r_cbonus;
    assign cur_rbonus = i_frame_start ? '0 : r_rbonus;

    assign row_hit   = (TW'(cur_srow) == cur_rtgt) && (cur_orow < i_oh);
    assign col_hit   = row_hit && (cur_ocol < i_ow) && (TW'(cur_scol) == cur_ctgt);
    assign row_end   = (cur_scol >= i_sw - 1'b1);
    assign frame_end = (cur_srow >= i_sh - 1'b1);

    // quotient of (rem + size) / out split into the fixed ratio plus one carry
    assign csum      = {1'b0, cur_cmod} + {1'b0, i_rw};
    assign ccarry    = (csum >= {1'b0, i_ow});
    assign cmod_step = ccarry ? DW'(csum - {1'b0, i_ow}) : DW'(csum);
    assign ctgt_step = cur_ctgt + TW'(i_qw) + TW'(cur_cbonus) + TW'(ccarry);

    assign rsum      = {1'b0, cur_rmod} + {1'b0, i_rh};
    assign rcarry    = (rsum >= {1'b0, i_oh});
    assign rmod_step = rcarry ? DW'(rsum - {1'b0, i_oh}) : DW'(rsum);
    assign rtgt_step = cur_rtgt + TW'(i_qh) + TW'(cur_rbonus) + TW'(rcarry);

    always_comb begin
        n_scol   = r_scol;
        n_srow   = r_srow;
        n_ocol   = r_ocol;
        n_orow   = r_orow;
        n_ctgt   = r_ctgt;
        n_rtgt   = r_rtgt;
        n_craw   = r_craw;
        n_rraw   = r_rraw;
        n_cmod   = r_cmod;
        n_rmod   = r_rmod;
        n_cbonus = r_cbonus;
        n_rbonus = r_rbonus;
        if (i_accept) begin
            n_scol   = cur_scol;
            n_srow   = cur_srow;
            n_ocol   = cur_ocol;
            n_orow   = cur_orow;
            n_ctgt   = cur_ctgt;
            n_rtgt   = cur_rtgt;
            n_craw   = i_frame_start ? '0 : r_craw;
            n_rraw   = i_frame_start ? '0 : r_rraw;
            n_cmod   = cur_cmod;
            n_rmod   = cur_rmod;
            n_cbonus = cur_cbonus;
            n_rbonus = cur_rbonus;
            if (col_hit) begin
                n_ocol   = cur_ocol + 1'b1;
                n_ctgt   = ctgt_step;
                n_craw   = cmod_step;
                n_cmod   = cmod_step;
                n_cbonus = '0;
            end
            if (row_end) begin
                if (row_hit) begin
                    n_orow   = cur_orow + 1'b1;
                    n_rtgt   = rtgt_step;
                    n_rraw   = rmod_step;
                    n_rmod   = rmod_step;
                    n_rbonus = '0;
                end
                n_ocol   = '0;
                n_ctgt   = '0;
                n_craw   = '0;
                n_cmod   = '0;
                n_cbonus = '0;
                n_scol   = '0;
                if (frame_end) begin
                    n_srow   = '0;
                    n_orow   = '0;
                    n_rtgt   = '0;
                    n_rraw   = '0;
                    n_rmod   = '0;
                    n_rbonus = '0;
                end else begin
                    n_srow = cur_srow + 1'b1;
                end
            end else begin
                n_scol = cur_scol + 1'b1;
            end
        end
        // a size change re-splits the stored remainders against the new divisor
        if (i_norm.col) begin
            n_cmod   = i_norm_rem;
            n_cbonus = i_norm_quot;
        end
        if (i_norm.row) begin
            n_rmod   = i_norm_rem;
            n_rbonus = i_norm_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol   <= '0;
            r_srow   <= '0;
            r_ocol   <= '0;
            r_orow   <= '0;
            r_ctgt   <= '0;
            r_rtgt   <= '0;
            r_craw   <= '0;
            r_rraw   <= '0;
            r_cmod   <= '0;
            r_rmod   <= '0;
            r_cbonus <= '0;
            r_rbonus <= '0;
        end else begin
            r_scol   <= n_scol;
            r_srow   <= n_srow;
            r_ocol   <= n_ocol;
            r_orow   <= n_orow;
            r_ctgt   <= n_ctgt;
            r_rtgt   <= n_rtgt;
            r_craw   <= n_craw;
            r_rraw   <= n_rraw;
            r_cmod   <= n_cmod;
            r_rmod   <= n_rmod;
            r_cbonus <= n_cbonus;
            r_rbonus <= n_rbonus;
        end
    end

    assign o_col_raw   = r_craw;
    assign o_row_raw   = r_rraw;
    assign o_res_valid = i_accept && col_hit;
    assign o_res.pix   = i_pixel - PIXEL_OFFSET;
    assign o_res.x     = COORD_W'(cur_ocol);
    assign o_res.y     = COORD_W'(cur_orow);
    assign o_res.last  = (cur_ocol == i_ow - 1'b1) && (cur_orow == i_oh - 1'b1);

endmodule

// File: sv/nncd_obuf.sv
// ----------------------------------------------------------------------------
// nncd_obuf
// two-entry output register with skid slot
// ----------------------------------------------------------------------------
module nncd_obuf
    import nncd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       pop;
    logic       push;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_space = (r_cnt != 2'd2);
    assign push    = i_push && o_space;

    always_comb begin
        n_cnt = r_cnt;
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_slot0 <= r_slot1;
            end else if (push) begin
                r_slot0 <= i_data;
            end
        end else if (push && r_cnt == 2'd0) begin
            r_slot0 <= i_data;
        end
        if (push && ((r_cnt == 2'd1 && !pop) || (r_cnt == 2'd2 && pop))) begin
            r_slot1 <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;

endmodule

// File: sv/nearest_neighbor_crop_downscale_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_crop_downscale_unit
// nearest-neighbor crop and downscale of a raster grayscale pixel stream
// ----------------------------------------------------------------------------
// Takes one source pixel per clock while neither a configuration recompute
// nor a full output buffer holds the input off, and emits through a register
// the pixels that fall on the nearest-neighbor grid of the cropped output
// image, each as pixel minus 128 with its output coordinates and an
// end-of-frame mark on tlast. The scan keeps a target and remainder per axis,
// so the pick needs no divider in the pixel path; a two-entry output buffer
// keeps the input open while one result waits. Each configuration write
// holds the input off while one shared restoring divider recomputes both
// axis step ratios and re-splits the running remainders against the new sizes.
// ----------------------------------------------------------------------------
module nearest_neighbor_crop_downscale_unit
    import nncd_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [7:0] pixel
    input  logic                   i_s_axis_tuser,   // [0] frame_start
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [7:0] out_pixel, [17:8] out_x,
                                                     // [27:18] out_y, [31:28] zero
    output logic                   o_m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int TW = DW + 2;

    logic          busy;
    logic          buf_space;
    logic          accept;
    logic [DW-1:0] sw, sh, ow, oh, qw, rw, qh, rh;
    logic [DW-1:0] col_raw, row_raw;
    t_norm_ctl     norm;
    logic [DW-1:0] norm_quot, norm_rem;
    logic          res_valid;
    t_result       res;
    t_result       out_res;

    assign o_s_axis_tready = !busy && buf_space;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    nncd_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .DW            (DW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_col_raw   (col_raw),
        .i_row_raw   (row_raw),
        .o_busy      (busy),
        .o_sw        (sw),
        .o_sh        (sh),
        .o_ow        (ow),
        .o_oh        (oh),
        .o_qw        (qw),
        .o_rw        (rw),
        .o_qh        (qh),
        .o_rh        (rh),
        .o_norm      (norm),
        .o_norm_quot (norm_quot),
        .o_norm_rem  (norm_rem)
    );

    nncd_scan #(
        .DW (DW),
        .TW (TW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel       (i_s_axis_tdata[PIX_W-1:0]),
        .i_frame_start (i_s_axis_tuser),
        .i_sw          (sw),
        .i_sh          (sh),
        .i_ow          (ow),
        .i_oh          (oh),
        .i_qw          (qw),
        .i_rw          (rw),
        .i_qh          (qh),
        .i_rh          (rh),
        .i_norm        (norm),
        .i_norm_quot   (norm_quot),
        .i_norm_rem    (norm_rem),
        .o_col_raw     (col_raw),
        .o_row_raw     (row_raw),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    nncd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (buf_space),
        .o_valid (o_m_axis_tvalid),
        .o_data  (out_res),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, out_res.y, out_res.x, out_res.pix};
    assign o_m_axis_tlast = out_res.last;

endmodule

// File: sv/nncd_checker.sv
// ----------------------------------------------------------------------------
// nncd_checker
// port-level checks on the crop and downscale unit, bound to the top level
// ----------------------------------------------------------------------------
`include "nearest_neighbor_crop_downscale_unit_macros.svh"

module nncd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic i_s_axis_tuser,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic i_cfg_valid,
    input logic o_cfg_ready
);

    // a stalled result stays offered
    `NNCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // pixel input never open while the size registers are locked
    `NNCD_ASSERT_IMPLY(a_ready_order, i_clk, i_rst_n, o_s_axis_tready, o_cfg_ready)

    // a register write starts the ratio recompute, which holds off both sides
    `NNCD_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !o_s_axis_tready && !o_cfg_ready)

    // the first pixel of a frame always maps to output pixel zero
    `NNCD_ASSERT_NEXT(a_frame_first_out, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser, o_m_axis_tvalid)

endmodule

bind nearest_neighbor_crop_downscale_unit nncd_checker u_nncd_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for nearest_neighbor_crop_downscale_unit
// streams grayscale source pixels through the crop and downscale unit under
// a series of register settings and checks every picked output pixel, its
// coordinates and the end-of-frame mark against a cycle-free scan predictor
// ----------------------------------------------------------------------------
module testbench;
    import nncd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;   // index with no register behind it
    localparam int MAX_DIM   = DEF_MAX_DIMENSION;
    localparam int IDLE_PCT  = 12;
    localparam int DRAIN_CYC = 12;
    localparam int HOLD_CYC  = 400;

    typedef struct packed {
        logic             fs;
        logic [PIX_W-1:0] pix;
    } t_src_px;

    logic                   i_clk;
    logic                   rst_n     = 1'b0;
    logic                   s_valid   = 1'b0;
    logic [PIX_W-1:0]       s_pix     = '0;
    logic                   s_fs      = 1'b0;
    logic                   m_ready   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_SRC_WIDTH;
    logic [CFG_W-1:0]       cfg_data  = '0;

    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   o_cfg_ready;

    nearest_neighbor_crop_downscale_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_pix),
        .i_s_axis_tuser  (s_fs),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // scan predictor: register copies and scan state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_src_w  = CFG_W'(RST_SRC_WIDTH);
    logic [CFG_W-1:0] cfg_src_h  = CFG_W'(RST_SRC_HEIGHT);
    logic [CFG_W-1:0] cfg_crop_h = CFG_W'(RST_CROP_HEIGHT);
    logic [CFG_W-1:0] cfg_out_w  = CFG_W'(RST_OUT_WIDTH);
    logic [CFG_W-1:0] cfg_out_h  = CFG_W'(RST_OUT_HEIGHT);

    int unsigned src_col, src_row, out_col, out_row;
    int unsigned col_target, col_rem, row_target, row_rem;

    t_src_px pixel_q[$];
    t_result picked_q[$];

    int  err_count   = 0;
    bit  no_idle     = 1'b0;
    bit  stall_armed = 1'b0;
    bit  stall_done;
    int  hold_left;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_scan();
        src_col = 0; src_row = 0;
        out_col = 0; out_row = 0;
        col_target = 0; col_rem = 0;
        row_target = 0; row_rem = 0;
    endfunction

    // advances the scan by one source pixel, returns 1 when it is picked
    function automatic bit pick_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                                      output t_result res);
        int unsigned sw, sh, ch, ow, oh;
        bit row_hit, hit;
        sw = clamp_dim(32'(cfg_src_w), MAX_DIM);
        sh = clamp_dim(32'(cfg_src_h), MAX_DIM);
        ch = clamp_dim(32'(cfg_crop_h), sh);
        ow = clamp_dim(32'(cfg_out_w), sw);
        oh = clamp_dim(32'(cfg_out_h), ch);
        hit = 1'b0;
        res = '0;
        if (fs) restart_scan();
        row_hit = (src_row == row_target) && (out_row < oh);
        if (row_hit && out_col < ow && src_col == col_target) begin
            res.pix  = pix - PIXEL_OFFSET;
            res.x    = out_col[COORD_W-1:0];
            res.y    = out_row[COORD_W-1:0];
            res.last = (out_col == ow - 1) && (out_row == oh - 1);
            hit = 1'b1;
            out_col++;
            col_rem    += sw;
            col_target += col_rem / ow;
            col_rem     = col_rem % ow;
        end
        if (src_col >= sw - 1) begin
            if (row_hit) begin
                out_row++;
                row_rem    += ch;
                row_target += row_rem / oh;
                row_rem     = row_rem % oh;
            end
            out_col = 0; col_target = 0; col_rem = 0;
            src_col = 0;
            // end of source frame restarts the scan on its own
            if (src_row >= sh - 1) restart_scan();
            else src_row++;
        end else begin
            src_col++;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // pixel driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        t_result res;
        t_src_px nxt;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                if (pick_pixel(s_pix, s_fs, res)) picked_q.push_back(res);
            end
            if (!s_valid || o_s_axis_tready) begin
                if (pixel_q.size() != 0 && (no_idle || $urandom_range(99, 0) >= IDLE_PCT)) begin
                    nxt = pixel_q.pop_front();
                    s_valid <= 1'b1;
                    s_pix   <= nxt.pix;
                    s_fs    <= nxt.fs;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: ready pattern and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            stall_done <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_armed && !stall_done && picked_q.size() != 0) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYC;
            stall_done <= 1'b1;
        end else begin
            m_ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_result got, want;
        string   exp_s, act_s;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            got.pix  = o_m_axis_tdata[PIX_W-1:0];
            got.x    = o_m_axis_tdata[PIX_W +: COORD_W];
            got.y    = o_m_axis_tdata[PIX_W+COORD_W +: COORD_W];
            got.last = o_m_axis_tlast;
            if (picked_q.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual pix=%02h x=%0d y=%0d last=%0b",
                         $realtime, got.pix, got.x, got.y, got.last);
                err_count++;
            end else begin
                want = picked_q.pop_front();
                if (got !== want || o_m_axis_tdata[OUT_TDATA_W-1:PIX_W+2*COORD_W] !== '0) begin
                    exp_s = $sformatf("pix=%02h x=%0d y=%0d last=%0b pad=0",
                                      want.pix, want.x, want.y, want.last);
                    act_s = $sformatf("pix=%02h x=%0d y=%0d last=%0b pad=%0h",
                                      got.pix, got.x, got.y, got.last,
                                      o_m_axis_tdata[OUT_TDATA_W-1:PIX_W+2*COORD_W]);
                    $display("%0t: output mismatch, expected %s, actual %s",
                             $realtime, exp_s, act_s);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH:   cfg_src_w  = val;
            CFG_SRC_HEIGHT:  cfg_src_h  = val;
            CFG_CROP_HEIGHT: cfg_crop_h = val;
            CFG_OUT_WIDTH:   cfg_out_w  = val;
            CFG_OUT_HEIGHT:  cfg_out_h  = val;
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int sw, input int sh, input int ch, input int ow, input int oh);
        write_reg(CFG_SRC_WIDTH, CFG_W'(sw));
        write_reg(CFG_SRC_HEIGHT, CFG_W'(sh));
        write_reg(CFG_CROP_HEIGHT, CFG_W'(ch));
        write_reg(CFG_OUT_WIDTH, CFG_W'(ow));
        write_reg(CFG_OUT_HEIGHT, CFG_W'(oh));
    endtask

    // wait until every pixel is taken and every picked pixel has come out
    task automatic settle(input int tail);
        while (pixel_q.size() != 0 || s_valid || picked_q.size() != 0) @(negedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    function automatic void push_px(input logic fs, input logic [PIX_W-1:0] pix);
        t_src_px px;
        px.fs  = fs;
        px.pix = pix;
        pixel_q.push_back(px);
    endfunction

    // n pixels with random content, a few stray frame starts as noise
    function automatic void queue_frames(input int n, input bit fresh);
        for (int k = 0; k < n; k++)
            push_px((k == 0 && fresh) || ($urandom_range(99, 0) < 3),
                    PIX_W'($urandom_range(255, 0)));
    endfunction

    // size value: mostly legal, sometimes zero or above the given bound
    function automatic int pick_dim(input int hi);
        int r;
        r = $urandom_range(99, 0);
        if (r < 6) return 0;
        if (r < 10) return $urandom_range(2047, hi + 1);
        return $urandom_range(hi, 1);
    endfunction

    initial begin : stim_proc
        logic [CFG_IDX_W-1:0] reg_ids [5];
        int sw, sh, ch, ow, oh, n, half, v;
        reg_ids = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_CROP_HEIGHT,
                    CFG_OUT_WIDTH, CFG_OUT_HEIGHT};
        restart_scan();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset sizes: extremes of the pixel value on picked and skipped columns
        push_px(1'b1, 8'h00); push_px(1'b0, 8'hFF); push_px(1'b0, 8'h80);
        push_px(1'b0, 8'h7F); push_px(1'b0, 8'h01); push_px(1'b0, 8'h02);
        push_px(1'b0, 8'hFE); push_px(1'b0, 8'h55); push_px(1'b0, 8'hAA);
        push_px(1'b0, 8'h80);
        // frame start in mid row
        push_px(1'b1, 8'hFF);
        settle(DRAIN_CYC);

        // tiny frame: cropped bottom row, end of frame and automatic restart
        set_sizes(4, 3, 2, 2, 2);
        queue_frames(14, 1'b1);
        settle(DRAIN_CYC);

        for (int ph = 0; ph < 14; ph++) begin
            no_idle     = (ph == 1);
            stall_armed = (ph == 2);
            case (ph)
                0: set_sizes(0, 0, 0, 0, 0);                  // all clamp to a single pixel
                1: set_sizes(12, 10, 10, 12, 10);
                2: set_sizes(8, 6, 6, 8, 6);                  // every pixel picked
                3: set_sizes(2047, 2047, 2047, 2047, 2047);
                4: set_sizes(1, 2047, 2047, 1, 2047);         // one-pixel-wide column
                default: begin
                    if (ph == 5) write_reg(CFG_SPARE, CFG_W'($urandom_range(2047, 0)));
                    sw = pick_dim(24);
                    sh = pick_dim(16);
                    ch = pick_dim(int'(clamp_dim(sh, MAX_DIM)));
                    ow = pick_dim(int'(clamp_dim(sw, MAX_DIM)));
                    oh = pick_dim(int'(clamp_dim(ch, clamp_dim(sh, MAX_DIM))));
                    set_sizes(sw, sh, ch, ow, oh);
                end
            endcase
            n = (ph == 2) ? 300 : $urandom_range(140, 60);
            if (ph >= 5 && ph % 2 == 1) begin
                // size change in mid frame
                half = n / 2;
                queue_frames(half, 1'b1);
                settle(DRAIN_CYC);
                v = ($urandom_range(3, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(24, 0);
                write_reg(reg_ids[$urandom_range(4, 0)], CFG_W'(v));
                queue_frames(n - half, 1'b0);
            end else begin
                queue_frames(n, 1'b1);
            end
            settle(DRAIN_CYC);
        end

        settle(20);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/nncd_pkg.sv
sv/nncd_div.sv
sv/nncd_cfg.sv
sv/nncd_scan.sv
sv/nncd_obuf.sv
sv/nearest_neighbor_crop_downscale_unit.sv
sv/nncd_checker.sv
tb/sv/testbench.sv
